FILE: src/mef_pkg.sv
`timescale 1ns / 1ps
package mef_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int CH_W      = 2;
  localparam int FRAC_W    = 16;
  localparam int AVG_W     = SAMPLE_W + FRAC_W;
  localparam int LEN_W     = 7;
  localparam int WEIGHT_W  = 17;
  localparam int REG_IDX_W = 3;

  localparam int IN_DATA_W  = ((CH_W + SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CH_W + SAMPLE_W + AVG_W + 7) / 8) * 8;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(1) << FRAC_W;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_WIN0   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIN1   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WIN2   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SEED   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT = 3'd4;

  localparam logic [LEN_W-1:0]    WIN0_RST   = 7'd11;
  localparam logic [LEN_W-1:0]    WIN1_RST   = 7'd21;
  localparam logic [LEN_W-1:0]    WIN2_RST   = 7'd51;
  localparam logic [LEN_W-1:0]    SEED_RST   = 7'd101;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd655;

  localparam logic [0:0] KIND_SAMPLE = 1'b0;
  localparam logic [0:0] KIND_CLEAR  = 1'b1;

  // Control broadcast to every cell of the sorter chain.
  typedef struct packed {
    logic                insert;
    logic                shift;
    logic [SAMPLE_W-1:0] sample;
  } cell_ctl_t;

endpackage

FILE: src/mef_cell.sv
`timescale 1ns / 1ps
module mef_cell #(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  mef_pkg::cell_ctl_t           ctl,
  input  logic [CW-1:0]                count,
  input  logic [mef_pkg::SAMPLE_W-1:0] left_val,
  input  logic                         left_gt,
  input  logic [mef_pkg::SAMPLE_W-1:0] right_val,
  output logic [mef_pkg::SAMPLE_W-1:0] value,
  output logic                         gt
);
  import mef_pkg::*;

  logic occ;

  assign occ = (32'(count) > IDX);
  assign gt  = occ && (value > ctl.sample);

  // On insert, a cell takes its left neighbor when that one moves up, takes
  // the new sample at the insertion point, and otherwise keeps its value.
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (left_gt) begin
        value <= left_val;
      end else if (gt || !occ) begin
        value <= ctl.sample;
      end
    end else if (ctl.shift) begin
      value <= right_val;
    end
  end

endmodule

FILE: src/mef_blend.sv
`timescale 1ns / 1ps
module mef_blend (
  input  logic                         clk,
  input  logic [mef_pkg::AVG_W-1:0]    avg,
  input  logic [mef_pkg::SAMPLE_W-1:0] median,
  input  logic [mef_pkg::WEIGHT_W-1:0] weight,
  output logic [mef_pkg::AVG_W-1:0]    avg_new
);
  import mef_pkg::*;

  localparam int P1_W  = AVG_W + WEIGHT_W;
  localparam int P2_W  = SAMPLE_W + WEIGHT_W;
  localparam int SUM_W = P1_W + 1;

  logic [WEIGHT_W-1:0] w_sat;
  logic [WEIGHT_W-1:0] w_inv;
  logic [P1_W-1:0]     p1;
  logic [P2_W-1:0]     p2;
  logic [SUM_W-1:0]    sum;

  assign w_sat = (weight > ONE_Q16) ? ONE_Q16 : weight;
  assign w_inv = ONE_Q16 - w_sat;
  assign sum   = SUM_W'(p1) + (SUM_W'(p2) << FRAC_W) + (SUM_W'(1) << (FRAC_W - 1));

  // Inputs are held steady by the controller; the products are registered first,
  // and the rounded sum is registered from them in the cycle after.
  always_ff @(posedge clk) begin
    p1      <= P1_W'(avg) * P1_W'(w_inv);
    p2      <= P2_W'(median) * P2_W'(w_sat);
    avg_new <= sum[FRAC_W +: AVG_W];
  end

endmodule

FILE: src/median_ema_sample_filter_core.sv
`timescale 1ns / 1ps
// An item that does not complete a window is handled in S_IN alone; one that completes
// a window goes on to S_SEEK, which shifts the median down the cell chain to cell 0,
// then, when a result is due, to S_MUL, S_SUM and S_PUSH (multiply, sum, output).
// The result is registered; the next item is taken while it waits downstream.
// Reset (synchronous, active high) restores the register defaults, empties the
// window and clears every channel's history; no clearing pass is needed.
module median_ema_sample_filter_core #(
  parameter int MAX_WINDOW   = 128,
  parameter int NUM_CHANNELS = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // channel [1:0], sample [13:2], zero fill above
  input  logic [mef_pkg::IN_DATA_W-1:0]    s_tdata,
  // kind [0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_channel [1:0], filtered_value [13:2], filtered_fixed [41:14], zero fill above
  output logic [mef_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                             cfg_we,
  input  logic [mef_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [mef_pkg::WEIGHT_W-1:0]     cfg_data
);
  import mef_pkg::*;

  localparam int CW  = $clog2(MAX_WINDOW);
  localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TW  = LEN_W + 2;
  localparam logic [TW-1:0] MAX_LEN = TW'(MAX_WINDOW - 1);
  localparam logic [SAMPLE_W:0] SAT_VAL = (SAMPLE_W + 1)'((1 << SAMPLE_W) - 1);

  typedef enum logic [2:0] {S_IN, S_SEEK, S_MUL, S_SUM, S_PUSH} state_t;

  state_t              state;
  logic [LEN_W-1:0]    win_len0, win_len1, win_len2, seed_len;
  logic [WEIGHT_W-1:0] weight;
  logic [CW-1:0]       count;
  logic [CH_W-1:0]     win_ch;
  logic [CHW-1:0]      win_idx;
  logic                seeding;
  logic [NUM_CHANNELS-1:0] ch_valid;
  logic [AVG_W-1:0]    avg_mem [NUM_CHANNELS];
  logic [CW-1:0]       seek_cnt;
  logic [SAMPLE_W-1:0] median;

  logic                accept;
  logic [0:0]          in_kind;
  logic [CH_W-1:0]     in_ch;
  logic [SAMPLE_W-1:0] in_sample;
  logic [CHW-1:0]      in_idx;
  logic                ch_ok;
  logic                do_insert;
  logic [CW-1:0]       count_eff;
  logic [CW-1:0]       count_new;
  logic                seeding_eff;
  logic [LEN_W-1:0]    len_sel;
  logic [TW-1:0]       len_odd;
  logic [TW-1:0]       target;
  logic                complete;
  cell_ctl_t           ctl;

  logic [SAMPLE_W-1:0] cell_val [MAX_WINDOW];
  logic                cell_gt  [MAX_WINDOW];

  logic [AVG_W-1:0]    avg_new;
  logic [AVG_W:0]      rnd_sum;
  logic [SAMPLE_W:0]   rnd;
  logic [SAMPLE_W-1:0] rnd_sat;
  logic                out_free;
  logic                push;

  assign s_tready  = (state == S_IN);
  assign accept    = s_tvalid && s_tready;
  assign in_kind   = s_tuser;
  assign in_ch     = s_tdata[CH_W-1:0];
  assign in_sample = s_tdata[CH_W +: SAMPLE_W];
  assign in_idx    = CHW'(in_ch);
  assign ch_ok     = (32'(in_ch) < NUM_CHANNELS);
  assign do_insert = accept && (in_kind == KIND_SAMPLE) && ch_ok;

  // A sample for another channel restarts the window.
  assign count_eff   = (win_ch != in_ch) ? '0 : count;
  assign count_new   = count_eff + CW'(1);
  assign seeding_eff = (count_eff == '0) ? !ch_valid[in_idx] : seeding;

  always_comb begin
    if (seeding_eff) begin
      len_sel = seed_len;
    end else begin
      case (in_ch)
        2'd1:    len_sel = win_len1;
        2'd2:    len_sel = win_len2;
        default: len_sel = win_len0;
      endcase
    end
  end

  assign len_odd  = len_sel[0] ? TW'(len_sel) : TW'(len_sel) + TW'(1);
  assign target   = (len_odd > MAX_LEN) ? MAX_LEN : len_odd;
  assign complete = (TW'(count_new) >= target);

  assign ctl.insert = do_insert;
  assign ctl.shift  = (state == S_SEEK) && (seek_cnt != '0);
  assign ctl.sample = in_sample;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_W-1:0] lv;
    logic                lg;
    logic [SAMPLE_W-1:0] rv;
    if (i == 0) begin : g_first
      assign lv = cell_val[0];
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cell_val[i-1];
      assign lg = cell_gt[i-1];
    end
    if (i == MAX_WINDOW - 1) begin : g_last
      assign rv = cell_val[i];
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end
    mef_cell #(.CW(CW), .IDX(i)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_eff),
      .left_val  (lv),
      .left_gt   (lg),
      .right_val (rv),
      .value     (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

  mef_blend u_blend (
    .clk     (clk),
    .avg     (avg_mem[win_idx]),
    .median  (median),
    .weight  (weight),
    .avg_new (avg_new)
  );

  assign rnd_sum  = (AVG_W + 1)'(avg_new) + (AVG_W + 1)'(1 << (FRAC_W - 1));
  assign rnd      = rnd_sum[FRAC_W +: SAMPLE_W + 1];
  assign rnd_sat  = (rnd > SAT_VAL) ? SAT_VAL[SAMPLE_W-1:0] : rnd[SAMPLE_W-1:0];
  assign out_free = !m_tvalid || m_tready;
  assign push     = (state == S_PUSH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len0 <= WIN0_RST;
      win_len1 <= WIN1_RST;
      win_len2 <= WIN2_RST;
      seed_len <= SEED_RST;
      weight   <= WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIN0:   win_len0 <= cfg_data[LEN_W-1:0];
        REG_WIN1:   win_len1 <= cfg_data[LEN_W-1:0];
        REG_WIN2:   win_len2 <= cfg_data[LEN_W-1:0];
        REG_SEED:   seed_len <= cfg_data[LEN_W-1:0];
        REG_WEIGHT: weight   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IN;
      count    <= '0;
      win_ch   <= '0;
      win_idx  <= '0;
      seeding  <= 1'b0;
      ch_valid <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IN: begin
          if (accept && (in_kind == KIND_CLEAR)) begin
            ch_valid <= '0;
            count    <= '0;
          end else if (do_insert) begin
            win_ch   <= in_ch;
            win_idx  <= in_idx;
            seeding  <= seeding_eff;
            seek_cnt <= count_new >> 1;
            if (complete) begin
              count <= '0;
              state <= S_SEEK;
            end else begin
              count <= count_new;
            end
          end
        end
        S_SEEK: begin
          if (seek_cnt != '0) begin
            seek_cnt <= seek_cnt - CW'(1);
          end else if (seeding) begin
            avg_mem[win_idx]  <= AVG_W'(cell_val[0]) << FRAC_W;
            ch_valid[win_idx] <= 1'b1;
            seeding           <= 1'b0;
            state             <= S_IN;
          end else begin
            median <= cell_val[0];
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (out_free) begin
            avg_mem[win_idx] <= avg_new;
            m_tdata          <= OUT_DATA_W'({avg_new, rnd_sat, win_ch});
            state            <= S_IN;
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

endmodule
